### hdl/lqr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LQR step package
// Shared constants, command/status types and saturating helpers.
// ----------------------------------------------------------------------------
package lqr_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DIV_BITS  = 33 + FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);

	localparam logic signed [31:0] DRIVE_MAX = 32'sd65536;
	localparam logic signed [31:0] DRIVE_MIN = 32'sd0;
	localparam logic signed [31:0] SLEW_MAX  = 32'sd655360;
	localparam logic signed [31:0] SLEW_MIN  = -32'sd655360;

	localparam logic signed [63:0] S32_MAX_W = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN_W = -64'sd2147483648;

	// configuration register indexes
	localparam logic [2:0] REG_GAIN_ERR  = 3'd0;
	localparam logic [2:0] REG_GAIN_RATE = 3'd1;
	localparam logic [2:0] REG_GAIN_INT  = 3'd2;
	localparam logic [2:0] REG_PERIOD    = 3'd3;
	localparam logic [2:0] REG_INT_MAX   = 3'd4;
	localparam logic [2:0] REG_INT_MIN   = 3'd5;
	localparam logic [2:0] REG_EST_GAIN  = 3'd6;
	localparam logic [2:0] REG_MODE      = 3'd7;

	// multiplier operand selects
	localparam logic [2:0] MS_ERRP = 3'd0;
	localparam logic [2:0] MS_EST  = 3'd1;
	localparam logic [2:0] MS_G0   = 3'd2;
	localparam logic [2:0] MS_G1   = 3'd3;
	localparam logic [2:0] MS_G2   = 3'd4;
	localparam logic [2:0] MS_UP   = 3'd5;
	localparam logic [2:0] MS_DN   = 3'd6;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic [2:0] mul_sel;
		logic       int_upd;
		logic       div_start;
		logic       rate_upd;
		logic       corr_upd;
		logic       acc_upd;
		logic       drv_upd;
		logic       up_upd;
		logic       dn_upd;
		logic       out_load;
	} lqr_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic est_en;
		logic out_free;
	} lqr_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX_W) r = 32'sh7fffffff;
		else if (v < S32_MIN_W) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] clamp_hf(input logic signed [31:0] v,
			input logic signed [31:0] hi, input logic signed [31:0] lo);
		logic signed [31:0] r;
		if (v > hi) r = hi;
		else if (v < lo) r = lo;
		else r = v;
		return r;
	endfunction

endpackage

### hdl/lqr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LQR step channels
// Valid/ready interfaces for samples and results.
// ----------------------------------------------------------------------------
interface lqr_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] measure;
	logic signed [31:0] target;
	modport source (output valid, measure, target, input ready);
	modport sink (input valid, measure, target, output ready);
endinterface

interface lqr_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] drive;
	logic signed [31:0] setpoint_err;
	logic signed [31:0] err_slope;
	logic signed [31:0] error_integral;
	modport source (output valid, drive, setpoint_err, err_slope, error_integral,
		input ready);
	modport sink (input valid, drive, setpoint_err, err_slope, error_integral,
		output ready);
endinterface

### hdl/lqr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LQR radix-2 divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lqr_div
	import lqr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIV_BITS-1:0] dividend,
	input  logic [30:0]         divisor,
	output logic                busy,
	output logic [DIV_BITS-1:0] quotient
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic [30:0]          rem_q;
	logic [DIV_BITS-1:0]  quo_q;
	logic [30:0]          dvs_q;
	logic [31:0]          rem_sh;
	logic                 fits;

	assign rem_sh   = {rem_q, quo_q[DIV_BITS-1]};
	assign fits     = rem_sh >= {1'b0, dvs_q};
	assign busy     = cnt_q != '0;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(DIV_BITS);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy) begin
			rem_q <= fits ? 31'(rem_sh - {1'b0, dvs_q}) : rem_sh[30:0];
			quo_q <= {quo_q[DIV_BITS-2:0], fits};
		end
	end

endmodule

### hdl/lqr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LQR step controller
// Sequences the shared multiplier, divider and state updates per sample.
// ----------------------------------------------------------------------------
module lqr_ctrl
	import lqr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  lqr_sts_t sts,
	output lqr_cmd_t cmd
);

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_MUL_I = 5'd1;
	localparam logic [4:0] ST_INTG  = 5'd2;
	localparam logic [4:0] ST_DIVW  = 5'd3;
	localparam logic [4:0] ST_MUL_E = 5'd4;
	localparam logic [4:0] ST_CORR  = 5'd5;
	localparam logic [4:0] ST_MG0   = 5'd6;
	localparam logic [4:0] ST_AC0   = 5'd7;
	localparam logic [4:0] ST_MG1   = 5'd8;
	localparam logic [4:0] ST_AC1   = 5'd9;
	localparam logic [4:0] ST_MG2   = 5'd10;
	localparam logic [4:0] ST_AC2   = 5'd11;
	localparam logic [4:0] ST_DRV   = 5'd12;
	localparam logic [4:0] ST_MUP   = 5'd13;
	localparam logic [4:0] ST_UP    = 5'd14;
	localparam logic [4:0] ST_MDN   = 5'd15;
	localparam logic [4:0] ST_DN    = 5'd16;
	localparam logic [4:0] ST_OUT   = 5'd17;

	logic [4:0] state_q, state_d;

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL_I;
				end
			end
			ST_MUL_I: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_ERRP;
				state_d     = ST_INTG;
			end
			ST_INTG: begin
				cmd.int_upd   = 1'b1;
				cmd.div_start = 1'b1;
				state_d       = ST_DIVW;
			end
			ST_DIVW: begin
				if (!sts.div_busy) begin
					cmd.rate_upd = 1'b1;
					state_d      = sts.est_en ? ST_MUL_E : ST_MG0;
				end
			end
			ST_MUL_E: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_EST;
				state_d     = ST_CORR;
			end
			ST_CORR: begin
				cmd.corr_upd = 1'b1;
				state_d      = ST_MG0;
			end
			ST_MG0: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_G0;
				state_d     = ST_AC0;
			end
			ST_AC0: begin
				cmd.acc_upd = 1'b1;
				state_d     = ST_MG1;
			end
			ST_MG1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_G1;
				state_d     = ST_AC1;
			end
			ST_AC1: begin
				cmd.acc_upd = 1'b1;
				state_d     = ST_MG2;
			end
			ST_MG2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_G2;
				state_d     = ST_AC2;
			end
			ST_AC2: begin
				cmd.acc_upd = 1'b1;
				state_d     = ST_DRV;
			end
			ST_DRV: begin
				cmd.drv_upd = 1'b1;
				state_d     = ST_MUP;
			end
			ST_MUP: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_UP;
				state_d     = ST_UP;
			end
			ST_UP: begin
				cmd.up_upd = 1'b1;
				state_d    = ST_MDN;
			end
			ST_MDN: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_DN;
				state_d     = ST_DN;
			end
			ST_DN: begin
				cmd.dn_upd = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hdl/lqr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LQR step datapath
// Configuration, controller state, shared multiplier and result register.
// ----------------------------------------------------------------------------
module lqr_dp
	import lqr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_data,
	input  logic signed [31:0] measure,
	input  logic signed [31:0] target,
	input  lqr_cmd_t           cmd,
	output lqr_sts_t           sts,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] drive,
	output logic signed [31:0] setpoint_err,
	output logic signed [31:0] err_slope,
	output logic signed [31:0] error_integral
);

	logic signed [31:0] gain_err_q, gain_rate_q, gain_int_q, int_max_q, int_min_q, est_gain_q;
	logic [30:0]        period_q;
	logic [1:0]         mode_q;

	logic signed [31:0] err_st_q, rate_st_q, int_st_q, prev_q;
	logic signed [31:0] meas_q, err_q, drv_q, up_q, dn_q;
	logic signed [33:0] acc_q;
	logic signed [63:0] prod_q;
	logic               dq_neg_q;
	logic               out_valid_q;

	logic signed [31:0] mul_a, mul_b, qv, integ, est, dlt, fin;
	logic signed [32:0] dif;
	logic [32:0]        dif_mag;
	logic [DIV_BITS-1:0] quo;
	logic signed [DIV_BITS:0] qs;
	logic               div_busy;
	logic               per_zero;

	assign per_zero = period_q == '0;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_err_q  <= '0;
			gain_rate_q <= '0;
			gain_int_q  <= '0;
			period_q    <= 31'd655;
			int_max_q   <= 32'sh7fffffff;
			int_min_q   <= 32'sh80000000;
			est_gain_q  <= '0;
			mode_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_GAIN_ERR:  gain_err_q  <= cfg_data;
				REG_GAIN_RATE: gain_rate_q <= cfg_data;
				REG_GAIN_INT:  gain_int_q  <= cfg_data;
				REG_PERIOD:    period_q    <= cfg_data[30:0];
				REG_INT_MAX:   int_max_q   <= cfg_data;
				REG_INT_MIN:   int_min_q   <= cfg_data;
				REG_EST_GAIN:  est_gain_q  <= cfg_data;
				REG_MODE:      mode_q      <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// shared multiplier operands
	assign est = sat32(64'(meas_q) - 64'(err_st_q));

	always_comb begin
		unique case (cmd.mul_sel)
			MS_ERRP: begin mul_a = err_q;       mul_b = $signed({1'b0, period_q}); end
			MS_EST:  begin mul_a = est_gain_q;  mul_b = est;                       end
			MS_G0:   begin mul_a = gain_err_q;  mul_b = err_st_q;                  end
			MS_G1:   begin mul_a = gain_rate_q; mul_b = rate_st_q;                 end
			MS_G2:   begin mul_a = gain_int_q;  mul_b = int_st_q;                  end
			MS_UP:   begin mul_a = SLEW_MAX;    mul_b = $signed({1'b0, period_q}); end
			MS_DN:   begin mul_a = SLEW_MIN;    mul_b = $signed({1'b0, period_q}); end
			default: begin mul_a = '0;          mul_b = '0;                        end
		endcase
	end

	// floor-scaled, saturated product
	assign qv = sat32(prod_q >>> FRAC_BITS);

	always_comb begin
		integ = sat32(64'(int_st_q) + 64'(qv));
		if (mode_q[0]) integ = clamp_hf(integ, int_max_q, int_min_q);
	end

	// rate divider
	assign dif     = 33'(err_q) - 33'(err_st_q);
	assign dif_mag = dif[32] ? 33'(-dif) : 33'(dif);
	assign qs      = dq_neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

	lqr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({dif_mag, {FRAC_BITS{1'b0}}}),
		.divisor  (period_q),
		.busy     (div_busy),
		.quotient (quo)
	);

	// slew window and final clamp
	always_comb begin
		dlt = clamp_hf(sat32(64'(drv_q) - 64'(prev_q)), up_q, dn_q);
		fin = clamp_hf(sat32(64'(prev_q) + 64'(dlt)), DRIVE_MAX, DRIVE_MIN);
		if (per_zero) fin = drv_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			meas_q <= measure;
			err_q  <= sat32(64'(target) - 64'(measure));
			acc_q  <= '0;
		end
		if (cmd.mul_en) prod_q <= mul_a * mul_b;
		if (cmd.div_start) dq_neg_q <= dif[32];
		if (cmd.acc_upd) acc_q <= acc_q - 34'(qv);
		if (cmd.drv_upd) drv_q <= clamp_hf(sat32(64'(acc_q)), DRIVE_MAX, DRIVE_MIN);
		if (cmd.up_upd) up_q <= qv;
		if (cmd.dn_upd) dn_q <= qv;
		if (cmd.out_load) begin
			drive          <= fin;
			setpoint_err   <= err_q;
			err_slope      <= rate_st_q;
			error_integral <= int_st_q;
		end
	end

	// controller state, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_st_q  <= '0;
			rate_st_q <= '0;
			int_st_q  <= '0;
			prev_q    <= '0;
		end else begin
			if (cmd.int_upd) begin
				int_st_q <= integ;
				err_st_q <= err_q;
			end
			if (cmd.rate_upd) rate_st_q <= per_zero ? 32'sd0 : sat32(64'(qs));
			if (cmd.corr_upd) begin
				err_st_q  <= sat32(64'(err_st_q) + 64'(qv));
				rate_st_q <= sat32(64'(rate_st_q) + 64'(qv));
				int_st_q  <= sat32(64'(int_st_q) + 64'(qv));
			end
			if (cmd.out_load) prev_q <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.div_busy = div_busy;
	assign sts.est_en   = mode_q[1];
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

### hdl/lqr_state_feedback_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LQR state-feedback step
// Error, rate and integral states, optional estimator correction, and a
// clamped, slew-limited drive, all in signed Q16.16.
// ----------------------------------------------------------------------------
//  channel    | role  | payload
//  sample_ch  | sink  | measure, target
//  result_ch  | source| drive, setpoint_err, err_slope, error_integral
//  cfg_*      | write | cfg_idx selects one of eight registers, cfg_data
//
//  One sample at a time; the next sample can be taken in the cycle after the
//  result is loaded. The 49-step rate divider takes up most of the work on
//  each sample.
//  sample_ch.ready is high only between samples. A finished result waits in
//  the output register; a stalled result_ch holds the next result back.
//  arst_n clears states, control, configuration and result valid to their defaults.
// ----------------------------------------------------------------------------
module lqr_state_feedback_step
	import lqr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	lqr_in_if.sink      sample_ch,
	lqr_out_if.source   result_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data
);

	lqr_cmd_t cmd;
	lqr_sts_t sts;

	// sequence each transaction through the shared units
	lqr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_ch.valid),
		.in_ready (sample_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// hold configuration, states and the result register
	lqr_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_data       (cfg_data),
		.measure        (sample_ch.measure),
		.target         (sample_ch.target),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (result_ch.valid),
		.out_ready      (result_ch.ready),
		.drive          (result_ch.drive),
		.setpoint_err   (result_ch.setpoint_err),
		.err_slope      (result_ch.err_slope),
		.error_integral (result_ch.error_integral)
	);

endmodule

### hdl/lqr_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LQR step port checker
// Port-level properties of the step block, bound to the top level.
// ----------------------------------------------------------------------------
module lqr_chk
	import lqr_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               s_valid,
	input logic               s_ready,
	input logic               r_valid,
	input logic               r_ready,
	input logic signed [31:0] r_drive
);

	// one sample in flight: ready drops right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && s_ready |=> !s_ready)
		else $error("sample accepted while busy");

	// no result appears the cycle after an accept
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && s_ready |=> !$rose(r_valid))
		else $error("result too early");

	// drive stays within its limits
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> (r_drive <= DRIVE_MAX) && (r_drive >= DRIVE_MIN))
		else $error("drive out of range");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_drive))
		else $error("stalled result changed");

endmodule

bind lqr_state_feedback_step lqr_chk u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_valid (sample_ch.valid),
	.s_ready (sample_ch.ready),
	.r_valid (result_ch.valid),
	.r_ready (result_ch.ready),
	.r_drive (result_ch.drive)
);
